FILE: hdl/aabb_pkg.sv
// ---------------------------------------------------------------------------
// aabb_pkg
// Shared types, codes and saturation helper for the slide collision resolver.
// ---------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

  localparam logic CMD_WALL = 1'b0;
  localparam logic CMD_MOVE = 1'b1;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  localparam logic signed [25:0] COORD_MAX = 26'sd8388607;
  localparam logic signed [25:0] COORD_MIN = -26'sd8388608;

  typedef struct packed {
    logic               cmd;
    logic [5:0]         wall_index;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [22:0]        size_w;
    logic [22:0]        size_h;
    logic signed [23:0] step_x;
    logic signed [23:0] step_y;
  } in_t;

  typedef struct packed {
    logic signed [23:0] new_x;
    logic signed [23:0] new_y;
  } out_t;

  typedef struct packed {
    logic signed [23:0] left;
    logic signed [23:0] top;
    logic [22:0]        width;
    logic [22:0]        height;
  } wall_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > COORD_MAX) begin
      return COORD_MAX[23:0];
    end else if (v < COORD_MIN) begin
      return COORD_MIN[23:0];
    end else begin
      return v[23:0];
    end
  endfunction

endpackage

`default_nettype wire

FILE: hdl/aabb_slide_collision_resolver_unit.sv
// ---------------------------------------------------------------------------
// aabb_slide_collision_resolver_unit
// Wall table in RAM and an axis by axis sweep that slides a box against it.
// ---------------------------------------------------------------------------
// Usage:
//   in channel (valid/ready) carries either a wall write (cmd 0) or a move
//   (cmd 1). A wall write stores into the wall RAM if wall_index is below
//   MAX_WALLS and gives no result. A move gives one transfer on the out
//   channel with the resolved position.
//   cfg_we_i/cfg_data_i set wall_count; values above MAX_WALLS act as
//   MAX_WALLS. Write it only while the block is idle.
//   A move sweeps the wall RAM once per axis, x then y, over the n
//   effective walls: each entry is read once per axis, one entry per cycle,
//   through the registered RAM read, and the result is loaded in S_DONE.
//   The next item is taken in the cycle after the result is loaded, so a
//   move holds off the input until then; a wall write leaves it ready.
//   The result sits in an output register, so the next item can be accepted
//   while it waits. If the receiver stalls with a result still held, a
//   finished move waits until the register frees.
//   Reset clears wall_count and the control state; wall RAM contents are
//   undefined until written and there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_slide_collision_resolver_unit #(
  parameter int unsigned MAX_WALLS = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire aabb_pkg::in_t  in_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output aabb_pkg::out_t      out_data_o,
  input  wire logic           cfg_we_i,
  input  wire logic [6:0]     cfg_data_i
);

  localparam int unsigned AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
  localparam int unsigned CW = $clog2(MAX_WALLS + 1);
  localparam int unsigned NW = (CW > 7) ? CW : 7;
  localparam int unsigned IW = (AW > 6) ? AW : 6;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_XPASS = 4'b0010,
    S_YPASS = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] n_q, n_d;
  logic [CW-1:0] iss_q, iss_d;
  logic          vld_q, vld_d;
  logic          out_valid_q, out_valid_d;

  // box registers
  logic signed [23:0] x_q, x_d, y_q, y_d, dx_q, dy_q;
  logic [22:0]        w_q, h_q;
  aabb_pkg::out_t     out_q;

  logic           accept, wr_en, rd_en, axis, load_out;
  logic [IW-1:0]  idx_ext;
  logic [AW-1:0]  wr_addr;
  aabb_pkg::wall_t wr_wall, rd_wall;
  logic signed [23:0] snap_coord;

  assign accept  = in_valid_i && in_ready_o;
  assign idx_ext = IW'(in_data_i.wall_index);
  assign wr_addr = idx_ext[AW-1:0];
  assign wr_en   = accept && (in_data_i.cmd == aabb_pkg::CMD_WALL) &&
                   (32'(in_data_i.wall_index) < 32'(MAX_WALLS));
  assign wr_wall = '{left:   in_data_i.pos_x,
                     top:    in_data_i.pos_y,
                     width:  in_data_i.size_w,
                     height: in_data_i.size_h};
  assign rd_en   = (state_q == S_XPASS || state_q == S_YPASS) && (iss_q < n_q);
  assign axis    = (state_q == S_YPASS) ? aabb_pkg::AXIS_Y : aabb_pkg::AXIS_X;

  aabb_ram #(
    .WIDTH ($bits(aabb_pkg::wall_t)),
    .DEPTH (MAX_WALLS)
  ) u_wall_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_wall),
    .re_i    (rd_en),
    .raddr_i (iss_q[AW-1:0]),
    .rdata_o (rd_wall)
  );

  aabb_snap u_snap (
    .axis_i   (axis),
    .box_x_i  (x_q),
    .box_y_i  (y_q),
    .box_w_i  (w_q),
    .box_h_i  (h_q),
    .step_x_i (dx_q),
    .step_y_i (dy_q),
    .wall_i   (rd_wall),
    .coord_o  (snap_coord)
  );

  always_comb begin
    n_d = n_q;
    if (cfg_we_i) begin
      if (NW'(cfg_data_i) > NW'(MAX_WALLS)) begin
        n_d = CW'(MAX_WALLS);
      end else begin
        n_d = CW'(cfg_data_i);
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    iss_d       = iss_q;
    vld_d       = 1'b0;
    x_d         = x_q;
    y_d         = y_q;
    load_out    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: begin
        if (accept && in_data_i.cmd == aabb_pkg::CMD_MOVE) begin
          x_d     = aabb_pkg::sat24(26'(in_data_i.pos_x) + 26'(in_data_i.step_x));
          y_d     = in_data_i.pos_y;
          iss_d   = '0;
          state_d = S_XPASS;
        end
      end
      S_XPASS, S_YPASS: begin
        // the entry read last cycle is resolved while the next one is read
        if (vld_q) begin
          if (state_q == S_YPASS) begin
            y_d = snap_coord;
          end else begin
            x_d = snap_coord;
          end
        end
        if (iss_q < n_q) begin
          iss_d = iss_q + 1'b1;
          vld_d = 1'b1;
        end else begin
          iss_d = '0;
          if (state_q == S_XPASS) begin
            y_d     = aabb_pkg::sat24(26'(y_q) + 26'(dy_q));
            state_d = S_YPASS;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      iss_q       <= '0;
      vld_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      iss_q       <= iss_d;
      vld_q       <= vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    if (accept && in_data_i.cmd == aabb_pkg::CMD_MOVE) begin
      w_q  <= in_data_i.size_w;
      h_q  <= in_data_i.size_h;
      dx_q <= in_data_i.step_x;
      dy_q <= in_data_i.step_y;
    end
    if (load_out) begin
      out_q <= '{new_x: x_q, new_y: y_q};
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_move_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.cmd == aabb_pkg::CMD_MOVE) |=> !in_ready_o)
    else $error("input not held off after a move transfer");

  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= n_q)
    else $error("read counter passed the wall count");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(n_q) <= 32'(MAX_WALLS))
    else $error("wall count above table depth");

  a_read_in_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q |-> (state_q == S_XPASS || state_q == S_YPASS))
    else $error("read data pending outside a sweep");
`endif

endmodule

`default_nettype wire

FILE: hdl/aabb_ram.sv
// ---------------------------------------------------------------------------
// aabb_ram
// Generic single write port, single read port RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/aabb_snap.sv
// ---------------------------------------------------------------------------
// aabb_snap
// Strict overlap test of the box against one wall and snap on the active axis.
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_snap (
  input  wire logic                  axis_i,
  input  wire logic signed [23:0]    box_x_i,
  input  wire logic signed [23:0]    box_y_i,
  input  wire logic [22:0]           box_w_i,
  input  wire logic [22:0]           box_h_i,
  input  wire logic signed [23:0]    step_x_i,
  input  wire logic signed [23:0]    step_y_i,
  input  wire aabb_pkg::wall_t       wall_i,
  output logic signed [23:0]         coord_o
);

  logic signed [25:0] cur, crs, cur_sz, crs_sz, lo, c_lo, span, c_span;
  logic signed [23:0] cur24, step;
  logic               hit;
  logic signed [25:0] snap_pos, snap_neg;

  always_comb begin
    if (axis_i == aabb_pkg::AXIS_Y) begin
      cur24  = box_y_i;
      step   = step_y_i;
      cur    = 26'(box_y_i);
      crs    = 26'(box_x_i);
      cur_sz = $signed({3'b000, box_h_i});
      crs_sz = $signed({3'b000, box_w_i});
      lo     = 26'(wall_i.top);
      c_lo   = 26'(wall_i.left);
      span   = $signed({3'b000, wall_i.height});
      c_span = $signed({3'b000, wall_i.width});
    end else begin
      cur24  = box_x_i;
      step   = step_x_i;
      cur    = 26'(box_x_i);
      crs    = 26'(box_y_i);
      cur_sz = $signed({3'b000, box_w_i});
      crs_sz = $signed({3'b000, box_h_i});
      lo     = 26'(wall_i.left);
      c_lo   = 26'(wall_i.top);
      span   = $signed({3'b000, wall_i.width});
      c_span = $signed({3'b000, wall_i.height});
    end

    // edges that only touch do not count
    hit = (cur < lo + span) && (cur + cur_sz > lo) &&
          (crs < c_lo + c_span) && (crs + crs_sz > c_lo);

    snap_pos = lo - cur_sz;
    snap_neg = lo + span;

    coord_o = cur24;
    if (hit) begin
      if (step > 24'sd0) begin
        coord_o = aabb_pkg::sat24(snap_pos);
      end else if (step < 24'sd0) begin
        coord_o = aabb_pkg::sat24(snap_neg);
      end
    end
  end

endmodule

`default_nettype wire
